### design/event_stream_message_framer_assert.svh
// Assertion macros used by the framer's engine, esmf_engine.
// Depends on nothing; take in by `include inside a module.
`ifndef EVENT_STREAM_MESSAGE_FRAMER_ASSERT_SVH
`define EVENT_STREAM_MESSAGE_FRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESMF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esmf: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ESMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esmf: next-cycle check failed");

`endif

### design/esmf_pkg.sv
// Types, constants and the bytewise CRC-32 step for the message framer.
// Depends on nothing; used by every module of the framer.
`default_nettype none

package esmf_pkg;

   localparam logic        CMD_START          = 1'b0;
   localparam logic        CMD_BYTE           = 1'b1;
   localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT           = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_XOROUT         = 32'hFFFF_FFFF;
   localparam logic [31:0] LENGTH_OVERHEAD    = 32'd16;

   // Positions within the 16-byte frame overhead
   localparam logic [3:0]  IDX_FIRST          = 4'd1;
   localparam logic [3:0]  IDX_PRELUDE_DATA   = 4'd7;
   localparam logic [3:0]  IDX_PRELUDE_END    = 4'd11;
   localparam logic [3:0]  IDX_MSG_CRC        = 4'd12;
   localparam logic [3:0]  IDX_LAST           = 4'd15;

   typedef struct packed {
      logic        cmd;
      logic [31:0] body_length;
      logic [31:0] header_length;
      logic [7:0]  data_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       end_of_message;
      logic       error;
   } rsp_word_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY_REFLECTED & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### design/event_stream_message_framer.sv
// Top level of the event-stream message framer with prelude and message CRC-32.
// Depends on esmf_pkg, esmf_in_reg, esmf_engine and esmf_out_reg.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   cmd, body_length, header_length, data_byte
//   rsp      out        rsp_valid/rsp_stall   out_byte, end_of_run, end_of_message, error
//
// One result byte leaves per cycle while rsp is not stalled; the engine emits one byte
// per cycle while the output register advances, each through a bytewise CRC-32 step.
// A start word yields the 12-byte prelude (16 bytes with an empty body); a body byte
// yields one byte, or five when it is the last one. A stray byte yields one error byte.
// Input register and output register decouple the two sides; a stall on rsp holds
// the engine, and req is stalled only while the held input word is not taken.
// Reset is synchronous: no message open, CRC all ones, both registers empty.
`default_nettype none

module event_stream_message_framer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_body_length,
   input  wire logic [31:0] req_header_length,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_end_of_run,
   output logic             rsp_end_of_message,
   output logic             rsp_error
);
   import esmf_pkg::*;

   logic         item_valid;
   req_word_type item;
   logic         take;
   logic         adv;
   logic         res_valid;
   rsp_word_type res;

   esmf_in_reg u_in_reg (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_body_length   (req_body_length),
      .req_header_length (req_header_length),
      .req_data_byte     (req_data_byte),
      .take              (take),
      .item_valid        (item_valid),
      .item              (item)
   );

   esmf_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .adv        (adv),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   esmf_out_reg u_out_reg (
      .clock              (clock),
      .reset              (reset),
      .res_valid          (res_valid),
      .res                (res),
      .adv                (adv),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_end_of_run     (rsp_end_of_run),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_error          (rsp_error)
   );

endmodule

`default_nettype wire

### design/esmf_in_reg.sv
// Input register of the framer: holds one request word until the engine takes it.
// Depends on esmf_pkg.
`default_nettype none

module esmf_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_cmd,
   input  wire logic [31:0]           req_body_length,
   input  wire logic [31:0]           req_header_length,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  take,
   output logic                       item_valid,
   output esmf_pkg::req_word_type     item
);
   import esmf_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type item_ff;
   logic         accept;

   assign req_stall  = valid_ff && !take;
   assign accept     = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= '{cmd: req_cmd, body_length: req_body_length,
                      header_length: req_header_length, data_byte: req_data_byte};
      end
   end

endmodule

`default_nettype wire

### design/esmf_engine.sv
// Framing engine: prelude, body pass-through, message CRC and stray errors; one byte per cycle while adv is high.
// Depends on esmf_pkg and event_stream_message_framer_assert.svh.
`default_nettype none
`include "event_stream_message_framer_assert.svh"

module esmf_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire esmf_pkg::req_word_type item,
   input  wire logic                  adv,
   output logic                       take,
   output logic                       res_valid,
   output esmf_pkg::rsp_word_type     res
);
   import esmf_pkg::*;

   logic        busy_ff,  busy_in;
   logic        open_ff,  open_in;
   logic [3:0]  idx_ff,   idx_in;
   logic [31:0] crc_ff,   crc_in;
   logic [31:0] pc_ff,    pc_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] hlen_ff,  hlen_in;
   logic [31:0] rem_ff,   rem_in;
   logic [31:0] total;
   logic [31:0] sel_word;
   logic [7:0]  sel_byte;
   logic        closed;

   always_comb begin
      case (idx_ff[3:2])
         2'd0:    sel_word = total_ff;
         2'd1:    sel_word = hlen_ff;
         2'd2:    sel_word = pc_ff;
         default: sel_word = crc_ff ^ CRC_XOROUT;
      endcase
      case (idx_ff[1:0])
         2'd0:    sel_byte = sel_word[31:24];
         2'd1:    sel_byte = sel_word[23:16];
         2'd2:    sel_byte = sel_word[15:8];
         default: sel_byte = sel_word[7:0];
      endcase
   end

   always_comb begin
      busy_in   = busy_ff;
      open_in   = open_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      pc_in     = pc_ff;
      total_in  = total_ff;
      hlen_in   = hlen_ff;
      rem_in    = rem_ff;
      take      = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      total     = item.body_length + LENGTH_OVERHEAD;

      if (adv && busy_ff) begin
         res_valid    = 1'b1;
         res.out_byte = sel_byte;
         idx_in       = idx_ff + 4'd1;
         if (idx_ff < IDX_MSG_CRC) begin
            crc_in = crc_byte(crc_ff, sel_byte);
         end
         if (idx_ff == IDX_PRELUDE_DATA) begin
            pc_in = crc_in ^ CRC_XOROUT;
         end
         if (idx_ff == IDX_PRELUDE_END && rem_ff != 32'd0) begin
            busy_in        = 1'b0;
            res.end_of_run = 1'b1;
         end
         if (idx_ff == IDX_LAST) begin
            res.end_of_run     = 1'b1;
            res.end_of_message = 1'b1;
            busy_in            = 1'b0;
            open_in            = 1'b0;
            rem_in             = 32'd0;
            crc_in             = CRC_INIT;
         end
      end else if (adv && item_valid) begin
         take      = 1'b1;
         res_valid = 1'b1;
         if (item.cmd == CMD_START) begin
            res.out_byte = total[31:24];
            crc_in       = crc_byte(CRC_INIT, total[31:24]);
            total_in     = total;
            hlen_in      = item.header_length;
            rem_in       = item.body_length;
            open_in      = 1'b1;
            busy_in      = 1'b1;
            idx_in       = IDX_FIRST;
         end else if (open_ff) begin
            res.out_byte = item.data_byte;
            crc_in       = crc_byte(crc_ff, item.data_byte);
            rem_in       = rem_ff - 32'd1;
            if (rem_ff == 32'd1) begin
               busy_in = 1'b1;
               idx_in  = IDX_MSG_CRC;
            end else begin
               res.end_of_run = 1'b1;
            end
         end else begin
            res.error      = 1'b1;
            res.end_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         open_ff <= 1'b0;
         idx_ff  <= '0;
         crc_ff  <= CRC_INIT;
         rem_ff  <= 32'd0;
      end else begin
         busy_ff <= busy_in;
         open_ff <= open_in;
         idx_ff  <= idx_in;
         crc_ff  <= crc_in;
         rem_ff  <= rem_in;
      end
      pc_ff    <= pc_in;
      total_ff <= total_in;
      hlen_ff  <= hlen_in;
   end

   assign closed = !open_ff && crc_ff == CRC_INIT && rem_ff == 32'd0;

   `ESMF_ASSERT_NOW(a_eom_ends_run, clock, reset, res_valid && res.end_of_message, res.end_of_run)
   `ESMF_ASSERT_NOW(a_error_only_closed, clock, reset, res_valid && res.error, !open_ff && !busy_ff)
   `ESMF_ASSERT_NEXT(a_eom_closes, clock, reset, res_valid && res.end_of_message, closed)

endmodule

`default_nettype wire

### design/esmf_out_reg.sv
// Output register of the framer: holds one result word until the sink takes it.
// Depends on esmf_pkg.
`default_nettype none

module esmf_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  res_valid,
   input  wire esmf_pkg::rsp_word_type res,
   output logic                       adv,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_end_of_run,
   output logic                       rsp_end_of_message,
   output logic                       rsp_error
);
   import esmf_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign adv                = !valid_ff || !rsp_stall;
   assign valid_in           = adv ? res_valid : valid_ff;
   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = word_ff.out_byte;
   assign rsp_end_of_run     = word_ff.end_of_run;
   assign rsp_end_of_message = word_ff.end_of_message;
   assign rsp_error          = word_ff.error;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (adv && res_valid) begin
         word_ff <= res;
      end
   end

endmodule

`default_nettype wire

### tb/tb_event_stream_message_framer.sv
`timescale 1ns / 1ps
// Self-checking testbench for event_stream_message_framer: random and directed words.
// Predicts prelude, body, message CRC and stray error bytes in a scoreboard class; uses esmf_pkg.
module tb_event_stream_message_framer;
   import esmf_pkg::*;

   class frame_scoreboard;
      rsp_word_type pending_bytes[$];
      logic [31:0]  body_crc;
      logic [31:0]  bytes_left;
      bit           msg_open;
      int           mismatches;
      int           bytes_checked;
      int           frames_closed;
      int           strays_seen;

      function new();
         body_crc      = CRC_INIT;
         bytes_left    = '0;
         msg_open      = 1'b0;
         mismatches    = 0;
         bytes_checked = 0;
         frames_closed = 0;
         strays_seen   = 0;
      endfunction

      static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c;
         for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY_REFLECTED;
            else r = r >> 1;
         end
         return r;
      endfunction

      function void push_byte(logic [7:0] b, bit eom, bit err);
         rsp_word_type w;
         w.out_byte       = b;
         w.end_of_run     = 1'b0;
         w.end_of_message = eom;
         w.error          = err;
         pending_bytes.push_back(w);
      endfunction

      function void push_word(logic [31:0] w, bit into_crc, bit last);
         logic [7:0] b;
         for (int s = 3; s >= 0; s--) begin
            b = w[8*s +: 8];
            if (into_crc) body_crc = crc_step(body_crc, b);
            push_byte(b, last && s == 0, 1'b0);
         end
      endfunction

      function void close_frame();
         push_word(body_crc ^ CRC_XOROUT, 1'b0, 1'b1);
         msg_open   = 1'b0;
         bytes_left = '0;
         body_crc   = CRC_INIT;
         frames_closed++;
      endfunction

      function void note_request(logic cmd, logic [31:0] blen, logic [31:0] hlen,
                                 logic [7:0] db);
         logic [31:0] total;
         logic [31:0] prelude_crc;
         if (cmd == CMD_START) begin
            total       = blen + LENGTH_OVERHEAD;
            prelude_crc = CRC_INIT;
            for (int s = 3; s >= 0; s--) prelude_crc = crc_step(prelude_crc, total[8*s +: 8]);
            for (int s = 3; s >= 0; s--) prelude_crc = crc_step(prelude_crc, hlen[8*s +: 8]);
            body_crc = CRC_INIT;
            push_word(total, 1'b1, 1'b0);
            push_word(hlen, 1'b1, 1'b0);
            push_word(prelude_crc ^ CRC_XOROUT, 1'b1, 1'b0);
            msg_open   = 1'b1;
            bytes_left = blen;
            if (blen == 0) close_frame();
         end else if (msg_open) begin
            body_crc = crc_step(body_crc, db);
            push_byte(db, 1'b0, 1'b0);
            bytes_left = bytes_left - 1;
            if (bytes_left == 0) close_frame();
         end else begin
            push_byte(8'h00, 1'b0, 1'b1);
            strays_seen++;
         end
         pending_bytes[pending_bytes.size() - 1].end_of_run = 1'b1;
      endfunction

      function void check_byte(rsp_word_type got);
         rsp_word_type exp;
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 30)
               $display("%0t: unexpected output word, expected none, actual %h", $time, got);
            return;
         end
         exp = pending_bytes.pop_front();
         if (exp == got) return;
         mismatches++;
         if (mismatches > 30) return;
         if (exp.out_byte != got.out_byte)
            $display("%0t: out_byte expected %h actual %h", $time, exp.out_byte, got.out_byte);
         if (exp.end_of_run != got.end_of_run)
            $display("%0t: end_of_run expected %b actual %b", $time,
                     exp.end_of_run, got.end_of_run);
         if (exp.end_of_message != got.end_of_message)
            $display("%0t: end_of_message expected %b actual %b", $time,
                     exp.end_of_message, got.end_of_message);
         if (exp.error != got.error)
            $display("%0t: error expected %b actual %b", $time, exp.error, got.error);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [31:0] req_body_length;
   logic [31:0] req_header_length;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_run;
   logic        rsp_end_of_message;
   logic        rsp_error;

   frame_scoreboard sb;
   bit              no_idle;
   int              stall_left;
   int              words_sent;

   event_stream_message_framer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_body_length    (req_body_length),
      .req_header_length  (req_header_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_end_of_run     (rsp_end_of_run),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_error          (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.out_byte       = rsp_out_byte;
         got.end_of_run     = rsp_end_of_run;
         got.end_of_message = rsp_end_of_message;
         got.error          = rsp_error;
         sb.check_byte(got);
      end
   end

   task automatic send_word(logic cmd, logic [31:0] blen, logic [31:0] hlen, logic [7:0] db);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_body_length   <= blen;
      req_header_length <= hlen;
      req_data_byte     <= db;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(cmd, blen, hlen, db);
      words_sent++;
   endtask

   task automatic send_start(logic [31:0] blen, logic [31:0] hlen);
      send_word(CMD_START, blen, hlen, 8'($urandom));
   endtask

   task automatic send_byte(logic [7:0] db);
      send_word(CMD_BYTE, $urandom, $urandom, db);
   endtask

   task automatic send_body(int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom));
   endtask

   function automatic logic [31:0] pick_body_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 0;
      if (r < 90) return $urandom_range(1, 8);
      if (r < 98) return $urandom_range(9, 24);
      return $urandom_range(40, 64);
   endfunction

   initial begin
      int          r;
      int          drain;
      logic [31:0] blen;
      sb                = new();
      no_idle           = 1'b0;
      stall_left        = 0;
      words_sent        = 0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_cmd           <= CMD_START;
      req_body_length   <= '0;
      req_header_length <= '0;
      req_data_byte     <= '0;
      rsp_stall         <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h5A);
      send_start(32'd0, 32'd0);
      send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_start(32'hFFFF_FFEF, 32'h1234_5678);
      send_byte(8'h80);
      send_byte(8'h01);
      send_start(32'd3, 32'd0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_byte(8'hFF);
      send_start(32'd1, 32'h8000_0000);
      send_byte(8'h7F);
      send_start(32'd2, 32'd1);
      send_byte(8'h55);
      send_start(32'd0, 32'hFFFF_FFFF);
      send_byte(8'h00);

      while (words_sent < 320) begin
         if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
         r = $urandom_range(0, 99);
         if (r < 68) begin
            blen = pick_body_length();
            send_start(blen, $urandom);
            send_body(blen);
         end else if (r < 80) begin
            if ($urandom_range(0, 1)) blen = $urandom;
            else blen = $urandom_range(2, 12);
            send_start(blen, $urandom);
            send_body($urandom_range(0, 3) % blen);
            blen = pick_body_length();
            send_start(blen, $urandom);
            send_body(blen);
         end else if (r < 92) begin
            if (sb.msg_open) send_start(32'd0, $urandom);
            send_body($urandom_range(1, 3));
         end else begin
            send_start(32'd0, $urandom);
         end
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      drain = 0;
      while (sb.pending_bytes.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (32) @(posedge clock);
      if (sb.pending_bytes.size() != 0) begin
         sb.mismatches++;
         $display("%0t: %0d output words expected, 0 received", $time,
                  sb.pending_bytes.size());
      end

      $display("Sent %0d input words: %0d frames closed, %0d stray bytes.",
               words_sent, sb.frames_closed, sb.strays_seen);
      $display("Checked %0d output words, %0d mismatches.", sb.bytes_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d output words outstanding.", sb.pending_bytes.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
